// ===== rtl/bpa_pkg.sv =====
// Shared types and constants for the bitmap page allocator.
// Used by bpa_ctrl, bpa_datapath and bitmap_page_allocator; depends on nothing.
package bpa_pkg;

  // Width of the page count register and of the page index fields.
  localparam int unsigned CountW = 13;
  localparam int unsigned PageW  = 12;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_REINIT = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Commands from the controller to the datapath and the output stage.
  typedef struct packed {
    logic load;    // latch the item, rewind the word walk
    logic sweep;   // write an all-used word and advance
    logic rd;      // read the current bitmap word
    logic adv;     // step to the next word
    logic set_wr;  // write back the word with the granted page marked used
    logic clr_wr;  // write back the word with the freed page cleared
    logic push;    // load the result into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic sweep_last;  // the sweep is at the last word
    logic past_limit;  // the current word starts at or beyond the page count
    logic hit;         // the word read holds a free page below the count
    logic page_oor;    // the page to free is at or beyond the page count
    logic in_word;     // the page to free lies in the current word
  } sts_t;

endpackage

// ===== rtl/bpa_ctrl.sv =====
// Controller state machine of the bitmap page allocator.
// Depends on bpa_pkg; drives the command struct of bpa_datapath.
module bpa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        op_i,
  input  logic              out_free_i,
  input  bpa_pkg::sts_t     sts_i,
  output bpa_pkg::cmd_t     cmd_o,
  output bpa_pkg::status_e  res_status_o,
  output logic              in_stall_o
);

  typedef enum logic [2:0] {
    S_SWEEP_RST,
    S_IDLE,
    S_A_CHECK,
    S_A_EVAL,
    S_F_CHECK,
    S_F_CLR,
    S_REINIT,
    S_DONE
  } state_e;

  state_e           state_q, state_d;
  bpa_pkg::status_e st_q, st_d;

  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    unique case (state_q)
      S_SWEEP_RST: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          st_d       = bpa_pkg::ST_DONE;
          unique case (bpa_pkg::op_e'(op_i))
            bpa_pkg::OP_ALLOC:  state_d = S_A_CHECK;
            bpa_pkg::OP_FREE:   state_d = S_F_CHECK;
            bpa_pkg::OP_REINIT: state_d = S_REINIT;
            bpa_pkg::OP_NONE:   state_d = S_DONE;
          endcase
        end
      end
      S_A_CHECK: begin
        if (sts_i.past_limit) begin
          st_d    = bpa_pkg::ST_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o.rd = 1'b1;
          state_d  = S_A_EVAL;
        end
      end
      S_A_EVAL: begin
        if (sts_i.hit) begin
          cmd_o.set_wr = 1'b1;
          state_d      = S_DONE;
        end else begin
          cmd_o.adv = 1'b1;
          state_d   = S_A_CHECK;
        end
      end
      S_F_CHECK: begin
        priority if (sts_i.page_oor) begin
          st_d    = bpa_pkg::ST_RANGE;
          state_d = S_DONE;
        end else if (sts_i.in_word) begin
          cmd_o.rd = 1'b1;
          state_d  = S_F_CLR;
        end else begin
          cmd_o.adv = 1'b1;
        end
      end
      S_F_CLR: begin
        cmd_o.clr_wr = 1'b1;
        state_d      = S_DONE;
      end
      S_REINIT: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result until the output register can take it.
        if (out_free_i) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP_RST;
      st_q    <= bpa_pkg::ST_DONE;
    end else begin
      state_q <= state_d;
      st_q    <= st_d;
    end
  end

  assign res_status_o = st_q;
  assign in_stall_o   = (state_q != S_IDLE);

endmodule

// ===== rtl/bpa_datapath.sv =====
// Datapath of the bitmap page allocator: bitmap memory, word walk counters,
// limit masking, free-bit priority encoder and the grant register. Uses bpa_pkg.
module bpa_datapath #(
  parameter int unsigned MAX_PAGES = 4096,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bpa_pkg::cmd_t                 cmd_i,
  input  logic [bpa_pkg::PageW-1:0]     page_i,
  input  logic [bpa_pkg::CountW-1:0]    page_count_i,
  output bpa_pkg::sts_t                 sts_o,
  output logic [bpa_pkg::PageW-1:0]     grant_o
);

  localparam int unsigned NumWords = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW       = (NumWords > 1) ? $clog2(NumWords) : 1;
  localparam int unsigned BW       = $clog2(WORD_BITS);
  localparam int unsigned CW       = bpa_pkg::CountW;
  localparam int unsigned BaseW    = bpa_pkg::CountW + 1;
  localparam int unsigned PW       = bpa_pkg::PageW;

  logic [WORD_BITS-1:0] mem [NumWords];
  logic [WORD_BITS-1:0] rdata_q;
  logic [WORD_BITS-1:0] wr_data;
  logic                 wr_en;

  logic [AW-1:0]        w_q;
  logic [BaseW-1:0]     base_q;
  logic [PW-1:0]        page_q;
  logic [PW-1:0]        grant_q;

  logic [CW-1:0]        limit;
  logic [BaseW-1:0]     rem;
  logic [BaseW-1:0]     diff;
  logic [WORD_BITS-1:0] avail;
  logic [BW-1:0]        hit_bit;
  logic [BW-1:0]        off;

  // Saturate the page count to the size of the bitmap.
  assign limit = (32'(page_count_i) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES) : page_count_i;

  assign rem  = {1'b0, limit} - base_q;
  assign diff = {{(BaseW-PW){1'b0}}, page_q} - base_q;
  assign off  = diff[BW-1:0];

  // Free pages of the word read, with pages at or beyond the count masked off.
  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      avail[i] = ~rdata_q[i] & (BaseW'(i) < rem);
    end
  end

  // Lowest free page wins.
  always_comb begin
    hit_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        hit_bit = BW'(i);
      end
    end
  end

  assign sts_o.sweep_last = (w_q == AW'(NumWords - 1));
  assign sts_o.past_limit = (base_q >= {1'b0, limit});
  assign sts_o.hit        = |avail;
  assign sts_o.page_oor   = ({1'b0, page_q} >= limit);
  assign sts_o.in_word    = (diff < BaseW'(WORD_BITS));

  assign wr_en = cmd_i.sweep | cmd_i.set_wr | cmd_i.clr_wr;

  always_comb begin
    priority if (cmd_i.sweep) begin
      wr_data = '1;
    end else if (cmd_i.set_wr) begin
      wr_data = rdata_q | (WORD_BITS'(1) << hit_bit);
    end else begin
      wr_data = rdata_q & ~(WORD_BITS'(1) << off);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[w_q] <= wr_data;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[w_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q    <= '0;
      base_q <= '0;
    end else begin
      if (cmd_i.load) begin
        w_q    <= '0;
        base_q <= '0;
      end else if (cmd_i.adv || cmd_i.sweep) begin
        w_q    <= w_q + AW'(1);
        base_q <= base_q + BaseW'(WORD_BITS);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      page_q  <= page_i;
      grant_q <= '0;
    end else if (cmd_i.set_wr) begin
      grant_q <= PW'(base_q + BaseW'(hit_bit));
    end
  end

  assign grant_o = grant_q;

endmodule

// ===== rtl/bitmap_page_allocator.sv =====
// Bitmap first-fit page allocator. Allocate reads the bitmap word by word and writes back
// the first word with a free page below the count with that page marked used (FULL if none);
// free steps to the page's word, reads it and clears the page (RANGE when out of range);
// reinit sweeps every word; output stalls delay the result. Items are taken one at a time,
// paced by the single-port bitmap and its read-modify-write. After reset a pass over every
// word marks every page used while input items are stalled; page count 4096.
module bitmap_page_allocator #(
  parameter int unsigned MAX_PAGES = 4096,
  parameter int unsigned WORD_BITS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 op_i,
  input  logic [bpa_pkg::PageW-1:0]  page_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [bpa_pkg::PageW-1:0]  granted_page_o,
  output logic [1:0]                 status_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned CW = bpa_pkg::CountW;

  logic [CW-1:0]             page_count_q;
  logic                      out_valid_q;
  logic [bpa_pkg::PageW-1:0] granted_q;
  bpa_pkg::status_e          status_q;
  logic                      out_free;
  logic                      cfg_wr;

  bpa_pkg::cmd_t             cmd;
  bpa_pkg::sts_t             sts;
  bpa_pkg::status_e          res_status;
  logic [bpa_pkg::PageW-1:0] grant;

  // Configuration port: one register, page_count, at byte address 0.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready & ~paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {{(32-CW){1'b0}}, page_count_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_count_q <= CW'(4096);
    end else if (cfg_wr) begin
      page_count_q <= pwdata[CW-1:0];
    end
  end

  assign out_free = ~out_valid_q | ~out_stall_i;

  bpa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .op_i         (op_i),
    .out_free_i   (out_free),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .res_status_o (res_status),
    .in_stall_o   (in_stall_o)
  );

  bpa_datapath #(
    .MAX_PAGES (MAX_PAGES),
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .page_i       (page_i),
    .page_count_i (page_count_q),
    .sts_o        (sts),
    .grant_o      (grant)
  );

  // Output register: holds a finished item while the next one is worked on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.push) begin
      granted_q <= grant;
      status_q  <= res_status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign granted_page_o = granted_q;
  assign status_o       = status_q;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.push && out_valid_q && out_stall_i))
    else $error("result pushed over a waiting item");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("item accepted while the previous one is still in work");

  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != bpa_pkg::ST_DONE) |-> (granted_page_o == '0))
    else $error("nonzero grant on a failed item");
`endif

endmodule
